@@ rtl/core/bfw_pkg.sv @@
// Shared types and constants of the bilateral filter window block.
package bfw_pkg;

    localparam logic [1:0] FUNC_PIXEL      = 2'd0;
    localparam logic [1:0] FUNC_FLUSH      = 2'd1;
    localparam logic [1:0] FUNC_LOAD_RANGE = 2'd2;
    localparam logic [1:0] FUNC_LOAD_SPACE = 2'd3;

    localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_RESERVED     = 2'd3;

    localparam int LANES        = 3;
    localparam int HEIGHT_W     = 13;
    localparam int WIDTH_W      = 12;
    localparam int CFG_DATA_W   = 13;
    localparam int TAP_IDX_W    = 9;
    localparam int WEIGHT_MAX_W = 24;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  pixel_b;
        logic [7:0]  pixel_g;
        logic [7:0]  pixel_r;
        logic [8:0]  table_index;
        logic [15:0] table_weight;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_b;
        logic [7:0] out_g;
        logic [7:0] out_r;
        logic       frame_last;
    } out_beat_t;

    typedef struct packed {
        logic                    centre_load;
        logic                    tap_valid;
        logic                    finish;
        logic [TAP_IDX_W-1:0]    tap_index;
    } lane_ctrl_t;

    typedef struct packed {
        logic                    range_we;
        logic                    spatial_we;
        logic [8:0]              index;
        logic [WEIGHT_MAX_W-1:0] weight;
    } tbl_wr_t;

endpackage

@@ rtl/core/bilateral_filter_window.sv @@
// Top level of the bilateral filter window block: line store, sequencer, lanes and merge.
//
// Pixels, flush ticks and table loads arrive as beats on the s_ channel; filtered
// pixels leave on the m_ channel, one beat per output pixel in raster order, with
// frame_last on the final pixel of a frame. The cfg channel writes color_mode,
// image_width and image_height while the block is idle; each write restarts the
// stream. A table load leaves the block idle and ready for the next beat. A pixel
// or flush beat that releases no output passes the window check and returns to idle.
// One that releases an output runs through the fetch, drain, finish and divide
// states: the window is read one tap per cycle from the single read port of the
// line store, feeds three channel lanes in parallel, then an eight step quotient unit
// in each lane forms the result. When every lane sees a zero weight sum, the quotient
// steps are skipped and each lane returns its centre pixel. A finished result waits
// in the output register, so the next beat is taken while the receiver stalls; the
// block only holds off when a second result is ready before the first was taken.
// Reset clears the counters and restores color mode, 640 pixels per row and 480 rows.
// Weight tables and the line store are not cleared and must be loaded before use.
module bilateral_filter_window #(
    parameter int WINDOW_SIZE    = 5,
    parameter int MAX_LINE_WIDTH = 2048,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bfw_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bfw_pkg::out_beat_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [bfw_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int TAPS      = WINDOW_SIZE * WINDOW_SIZE;
    localparam int HALF      = (WINDOW_SIZE - 1) / 2;
    localparam int CW        = $clog2(MAX_LINE_WIDTH);
    localparam int WDW       = CW + 1;
    localparam int RW        = bfw_pkg::HEIGHT_W;
    localparam int DEPTH     = WINDOW_SIZE * MAX_LINE_WIDTH;
    localparam int AW        = $clog2(DEPTH);
    localparam int TIW       = $clog2(TAPS);
    localparam int DCW       = $clog2(WINDOW_SIZE);
    localparam int WB        = WEIGHT_BITS;
    localparam int BACK_OFS  = HALF * MAX_LINE_WIDTH;
    localparam int FWD_OFS   = (WINDOW_SIZE - HALF) * MAX_LINE_WIDTH;
    localparam int LAST_BASE = (WINDOW_SIZE - 1) * MAX_LINE_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_FETCH  = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_DIV    = 6'b100000
    } state_t;

    state_t state_reg;

    logic [23:0] line_store [DEPTH];
    logic [23:0] rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic                           color_mode_reg;
    logic [bfw_pkg::WIDTH_W-1:0]    image_width_reg;
    logic [RW-1:0]                  image_height_reg;

    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [AW-1:0] in_base_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [AW-1:0] out_base_reg;

    logic signed [RW+1:0] row_u_reg;
    logic signed [CW+1:0] col_u_reg;
    logic signed [CW+1:0] col_start_reg;
    logic [AW-1:0]        row_base_reg;
    logic [DCW-1:0]       dc_reg;
    logic [TIW-1:0]       tap_reg;
    logic [2:0]           drain_reg;

    logic           tap_valid_d_reg;
    logic           centre_d_reg;
    logic [TIW-1:0] tap_d_reg;

    logic                out_valid_reg;
    bfw_pkg::out_beat_t  out_data_reg;

    logic [WDW-1:0] wd;
    logic [RW-1:0]  ht;
    logic           in_accept;
    logic           cfg_accept;
    logic           pixel_write;
    logic           out_free;
    logic [RW:0]    r_plus;
    logic [RW:0]    nr;
    logic [CW:0]    c_plus;
    logic [CW:0]    nc;
    logic           win_ready;
    logic signed [RW+1:0] row_start;
    logic [AW-1:0]  base_start;
    logic [CW-1:0]  col_cl;
    logic           row_grow;
    logic           col_last;
    logic           row_last;
    logic [WB+15:0] weight_ext;
    logic [23:0]    store_px;

    bfw_pkg::lane_ctrl_t ctrl;
    bfw_pkg::tbl_wr_t    tbl_wr;
    logic [7:0]          lane_result [bfw_pkg::LANES];
    logic                lane_done [bfw_pkg::LANES];
    logic                all_done;

    always_comb begin
        if (image_width_reg == '0) begin
            wd = WDW'(1);
        end else if (32'(image_width_reg) > MAX_LINE_WIDTH) begin
            wd = WDW'(MAX_LINE_WIDTH);
        end else begin
            wd = WDW'(image_width_reg);
        end
        ht = (image_height_reg == '0) ? RW'(1) : image_height_reg;
    end

    assign s_ready     = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign in_accept   = s_valid && s_ready;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign pixel_write = in_accept && (s_data.func == bfw_pkg::FUNC_PIXEL) && (in_row_reg < ht);
    assign out_free    = !out_valid_reg || m_ready;

    assign store_px = color_mode_reg ? {s_data.pixel_r, s_data.pixel_g, s_data.pixel_b}
                                     : {16'd0, s_data.pixel_b};

    assign r_plus = {1'b0, out_row_reg} + (RW+1)'(HALF);
    assign nr     = (r_plus >= {1'b0, ht}) ? {1'b0, ht} - (RW+1)'(1) : r_plus;
    assign c_plus = {1'b0, out_col_reg} + (CW+1)'(HALF);
    assign nc     = (c_plus >= wd) ? wd - WDW'(1) : c_plus;
    assign win_ready = (out_row_reg < ht)
                    && (({1'b0, in_row_reg} > nr)
                        || (({1'b0, in_row_reg} == nr) && ({1'b0, in_col_reg} > nc)));

    assign row_start = $signed({2'b00, out_row_reg}) - (RW+2)'(HALF);
    always_comb begin
        if (out_row_reg < RW'(HALF)) begin
            base_start = '0;
        end else if (out_base_reg >= AW'(BACK_OFS)) begin
            base_start = out_base_reg - AW'(BACK_OFS);
        end else begin
            base_start = out_base_reg + AW'(FWD_OFS);
        end
    end

    always_comb begin
        if (col_u_reg[CW+1]) begin
            col_cl = '0;
        end else if (col_u_reg >= $signed({1'b0, wd})) begin
            col_cl = CW'(wd - WDW'(1));
        end else begin
            col_cl = col_u_reg[CW-1:0];
        end
    end

    assign row_grow = !row_u_reg[RW+1] && ((row_u_reg + (RW+2)'(1)) < $signed({2'b00, ht}));
    assign rd_addr  = (state_reg == ST_CHECK) ? out_base_reg + AW'(out_col_reg)
                                              : row_base_reg + AW'(col_cl);
    assign col_last = ({1'b0, out_col_reg} + WDW'(1)) == wd;
    assign row_last = ({1'b0, out_row_reg} + (RW+1)'(1)) >= {1'b0, ht};

    always_ff @(posedge aclk) begin
        if (pixel_write) begin
            line_store[in_base_reg + AW'(in_col_reg)] <= store_px;
        end
        rd_data_reg <= line_store[rd_addr];
    end

    assign weight_ext = {s_data.table_weight, {WB{1'b0}}};
    always_comb begin
        tbl_wr.range_we   = in_accept && (s_data.func == bfw_pkg::FUNC_LOAD_RANGE)
                         && (s_data.table_index < 9'd256);
        tbl_wr.spatial_we = in_accept && (s_data.func == bfw_pkg::FUNC_LOAD_SPACE)
                         && (32'(s_data.table_index) < TAPS);
        tbl_wr.index      = s_data.table_index;
        tbl_wr.weight     = bfw_pkg::WEIGHT_MAX_W'(weight_ext[WB+15:16]);
        ctrl.centre_load  = centre_d_reg;
        ctrl.tap_valid    = tap_valid_d_reg;
        ctrl.finish       = (state_reg == ST_FINISH);
        ctrl.tap_index    = bfw_pkg::TAP_IDX_W'(tap_d_reg);
    end

    for (genvar k = 0; k < bfw_pkg::LANES; k++) begin : g_lane
        bfw_lane #(
            .WINDOW_SIZE (WINDOW_SIZE),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tbl_wr  (tbl_wr),
            .ctrl    (ctrl),
            .pixel   (rd_data_reg[8*k +: 8]),
            .result  (lane_result[k]),
            .done    (lane_done[k])
        );
    end

    assign all_done = lane_done[0] && lane_done[1] && lane_done[2];

    always_ff @(posedge aclk) begin
        tap_d_reg <= tap_reg;
        if (state_reg == ST_DIV && all_done && out_free) begin
            out_data_reg.out_b      <= lane_result[0];
            out_data_reg.out_g      <= color_mode_reg ? lane_result[1] : 8'd0;
            out_data_reg.out_r      <= color_mode_reg ? lane_result[2] : 8'd0;
            out_data_reg.frame_last <= col_last && row_last;
        end
        if (state_reg == ST_CHECK) begin
            row_u_reg     <= row_start;
            row_base_reg  <= base_start;
            col_u_reg     <= $signed({2'b00, out_col_reg}) - (CW+2)'(HALF);
            col_start_reg <= $signed({2'b00, out_col_reg}) - (CW+2)'(HALF);
            dc_reg        <= '0;
        end else if (state_reg == ST_FETCH) begin
            if (32'(dc_reg) == WINDOW_SIZE - 1) begin
                dc_reg    <= '0;
                col_u_reg <= col_start_reg;
                row_u_reg <= row_u_reg + (RW+2)'(1);
                if (row_grow) begin
                    row_base_reg <= (row_base_reg == AW'(LAST_BASE)) ? '0
                                  : row_base_reg + AW'(MAX_LINE_WIDTH);
                end
            end else begin
                dc_reg    <= dc_reg + DCW'(1);
                col_u_reg <= col_u_reg + (CW+2)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            color_mode_reg   <= 1'b1;
            image_width_reg  <= bfw_pkg::WIDTH_RESET;
            image_height_reg <= bfw_pkg::HEIGHT_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_base_reg      <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_base_reg     <= '0;
            tap_reg          <= '0;
            drain_reg        <= '0;
            tap_valid_d_reg  <= 1'b0;
            centre_d_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            tap_valid_d_reg <= (state_reg == ST_FETCH);
            centre_d_reg    <= (state_reg == ST_CHECK) && win_ready;
            if (state_reg == ST_DIV && all_done && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_accept && cfg_index != bfw_pkg::CFG_RESERVED) begin
                case (cfg_index)
                    bfw_pkg::CFG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                    bfw_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[bfw_pkg::WIDTH_W-1:0];
                    bfw_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default: ;
                endcase
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_base_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_base_reg <= '0;
            end
            if (pixel_write) begin
                if (({1'b0, in_col_reg} + WDW'(1)) >= wd) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + RW'(1);
                    in_base_reg <= (in_base_reg == AW'(LAST_BASE)) ? '0
                                 : in_base_reg + AW'(MAX_LINE_WIDTH);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept && (s_data.func == bfw_pkg::FUNC_PIXEL
                                      || s_data.func == bfw_pkg::FUNC_FLUSH)) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    tap_reg   <= '0;
                    state_reg <= win_ready ? ST_FETCH : ST_IDLE;
                end
                ST_FETCH: begin
                    tap_reg <= tap_reg + TIW'(1);
                    if (32'(tap_reg) == TAPS - 1) begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + 3'd1;
                    if (32'(drain_reg) == bfw_pkg::DRAIN_CYCLES - 1) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (all_done && out_free) begin
                        state_reg <= ST_IDLE;
                        if (col_last) begin
                            out_col_reg <= '0;
                            if (row_last) begin
                                out_row_reg  <= '0;
                                out_base_reg <= '0;
                                in_col_reg   <= '0;
                                in_row_reg   <= '0;
                                in_base_reg  <= '0;
                            end else begin
                                out_row_reg  <= out_row_reg + RW'(1);
                                out_base_reg <= (out_base_reg == AW'(LAST_BASE)) ? '0
                                              : out_base_reg + AW'(MAX_LINE_WIDTH);
                            end
                        end else begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/core/bfw_lane.sv @@
// One channel lane: weight tables, tap multiply-accumulate and quotient unit.
module bfw_lane #(
    parameter int WINDOW_SIZE = 5,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bfw_pkg::tbl_wr_t    tbl_wr,
    input  bfw_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]          pixel,
    output logic [7:0]          result,
    output logic                done
);

    localparam int TAPS = WINDOW_SIZE * WINDOW_SIZE;
    localparam int TIW  = $clog2(TAPS);
    localparam int TW   = $clog2(TAPS + 1);
    localparam int WB   = WEIGHT_BITS;
    localparam int NW   = WB + 8 + TW;
    localparam int DW   = WB + TW;

    logic [WB-1:0] range_mem [256];
    logic [WB-1:0] spatial_mem [TAPS];

    logic [7:0]      centre_reg;
    logic [7:0]      diff;
    logic [WB-1:0]   range_q_reg;
    logic [WB-1:0]   spatial_q_reg;
    logic [7:0]      pix_a_reg;
    logic            va_reg;
    logic [2*WB-1:0] prod_reg;
    logic [7:0]      pix_b_reg;
    logic            vb_reg;
    logic [WB-1:0]   w_reg;
    logic [WB+7:0]   wp_reg;
    logic            vc_reg;
    logic [NW-1:0]   num_reg;
    logic [DW-1:0]   den_reg;
    logic [NW-1:0]   rem_reg;
    logic [NW-1:0]   dsh_reg;
    logic [6:0]      quo_reg;
    logic [2:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [7:0]      result_reg;
    logic            ge;
    logic [WB-1:0]   w_next;

    assign diff   = (pixel > centre_reg) ? pixel - centre_reg : centre_reg - pixel;
    assign w_next = prod_reg[2*WB-1:WB];
    assign ge     = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (tbl_wr.range_we) begin
            range_mem[tbl_wr.index[7:0]] <= tbl_wr.weight[WB-1:0];
        end
        if (tbl_wr.spatial_we) begin
            spatial_mem[tbl_wr.index[TIW-1:0]] <= tbl_wr.weight[WB-1:0];
        end
        range_q_reg   <= range_mem[diff];
        spatial_q_reg <= spatial_mem[ctrl.tap_index[TIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.centre_load) begin
            centre_reg <= pixel;
        end
        pix_a_reg <= pixel;
        prod_reg  <= range_q_reg * spatial_q_reg;
        pix_b_reg <= pix_a_reg;
        w_reg     <= w_next;
        wp_reg    <= w_next * pix_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            num_reg  <= '0;
            den_reg  <= '0;
        end else begin
            va_reg <= ctrl.tap_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            if (ctrl.centre_load) begin
                num_reg  <= '0;
                den_reg  <= '0;
                done_reg <= 1'b0;
            end else if (vc_reg) begin
                num_reg <= num_reg + NW'(wp_reg);
                den_reg <= den_reg + DW'(w_reg);
            end
            if (ctrl.finish) begin
                if (den_reg == '0) begin
                    result_reg <= centre_reg;
                    done_reg   <= 1'b1;
                end else begin
                    rem_reg  <= num_reg;
                    dsh_reg  <= NW'(den_reg) << 7;
                    cnt_reg  <= 3'd7;
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg <= dsh_reg >> 1;
                quo_reg <= {quo_reg[5:0], ge};
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    result_reg <= {quo_reg, ge};
                end
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
